// File: rtl/rc_channel_frame_encoder_top_assert.svh
// Assertion macros for the radio control frame encoder.
// Included by rc_channel_frame_encoder_top; needs nothing else.
`ifndef RC_CHANNEL_FRAME_ENCODER_TOP_ASSERT_SVH
`define RC_CHANNEL_FRAME_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCFE_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCFE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rcfe_pkg.sv
// Shared types and constants for the radio control frame encoder.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
package rcfe_pkg;

   // Frame layout
   localparam int NUM_CHANNELS     = 16;
   localparam int CHAN_W           = 4;
   localparam int STICK_CHANNELS   = 4;
   localparam int THROTTLE_CHANNEL = 2;
   localparam int VALUE_W          = 11;
   localparam logic [7:0] HEAD_BYTE = 8'h55;

   // Stick scaling: (value + STICK_MAX) * span / (2 * STICK_MAX) via reciprocal multiply
   localparam int STICK_MAX   = 32767;
   localparam int DIVISOR     = 2 * STICK_MAX;
   localparam int NUM_W       = 17;
   localparam int PROD_W      = 28;
   localparam int RECIP_SHIFT = 28;
   localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'd1 << RECIP_SHIFT) / DIVISOR);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;
   localparam logic [10:0] SPAN_RESET   = 11'd1639;
   localparam logic [10:0] OFFSET_RESET = 11'd204;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPAN          = 3'd0,
      CSR_OFFSET        = 3'd1,
      CSR_SUB_PROTOCOL  = 3'd2,
      CSR_PROTOCOL_TYPE = 3'd3,
      CSR_RECEIVER      = 3'd4,
      CSR_OPTION        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] stick_value;
      logic               bind_ended;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [10:0]       span;
      logic [10:0]       offset;
      logic [6:0]        sub_protocol;
      logic [3:0]        protocol_type;
      logic [3:0]        receiver_number;
      logic signed [7:0] option_value;
   } cfg_type;

   // One finished channel word, as handed from front to back
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               first;
      logic               last;
      logic               bind_n;
   } chan_entry_type;

   // Packer state visible to the top level checks
   typedef struct packed {
      logic [3:0] held_bits;
      logic [1:0] header_left;
   } back_status_type;

endpackage

// File: rtl/rcfe_front.sv
// Front end: accepts channel words, tracks the channel index and scales stick channels.
// Three register stages feed the queue; depends on rcfe_pkg.
module rcfe_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rcfe_pkg::req_payload_type       req_payload,
   input  rcfe_pkg::cfg_type               cfg,
   input  logic [rcfe_pkg::QCNT_W-1:0]     q_count,
   output logic                            push_valid,
   output rcfe_pkg::chan_entry_type        push_entry
);

   localparam logic signed [rcfe_pkg::NUM_W-1:0] LIMIT =
      rcfe_pkg::NUM_W'(rcfe_pkg::STICK_MAX);
   localparam logic [rcfe_pkg::CHAN_W-1:0] LAST_CHAN =
      rcfe_pkg::CHAN_W'(rcfe_pkg::NUM_CHANNELS - 1);
   localparam logic [rcfe_pkg::CHAN_W-1:0] STICK_LIMIT =
      rcfe_pkg::CHAN_W'(rcfe_pkg::STICK_CHANNELS);
   localparam logic [rcfe_pkg::CHAN_W-1:0] THROTTLE =
      rcfe_pkg::CHAN_W'(rcfe_pkg::THROTTLE_CHANNEL);

   typedef struct packed {
      logic [rcfe_pkg::PROD_W-1:0]  prod;
      logic [rcfe_pkg::VALUE_W-1:0] raw;
      logic                         stick;
      logic                         throttle;
      logic                         first;
      logic                         last;
      logic                         bind_n;
   } stage_type;

   logic [rcfe_pkg::CHAN_W-1:0]       ch_ff, ch_in;
   logic                              accept;
   logic [1:0]                        inflight;
   logic [rcfe_pkg::QCNT_W:0]         occupancy;
   logic signed [rcfe_pkg::NUM_W-1:0] sample, clamped, shifted;
   logic [rcfe_pkg::NUM_W-1:0]        num;
   stage_type                         a_in;
   logic                              a_valid_ff, b_valid_ff, c_valid_ff;
   stage_type                         a_ff, b_ff;
   logic [2*rcfe_pkg::PROD_W-1:0]     recip_prod;
   logic [rcfe_pkg::VALUE_W-1:0]      b_q0_ff, b_q0_in;
   logic [rcfe_pkg::PROD_W-1:0]       back_prod, remainder;
   logic                              bump;
   logic [rcfe_pkg::VALUE_W-1:0]      quotient, scaled;
   rcfe_pkg::chan_entry_type          c_entry_ff, c_entry_in;

   // Admit a word only when the queue has room for it and everything in flight
   assign inflight  = 2'({1'b0, a_valid_ff}) + 2'({1'b0, b_valid_ff}) + 2'({1'b0, c_valid_ff});
   assign occupancy = {1'b0, q_count} + {3'b0, inflight};
   assign req_ready = occupancy < (rcfe_pkg::QCNT_W + 1)'(rcfe_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // Advance the channel index, wrap after the last channel
   always_comb begin
      ch_in = ch_ff;
      if (accept) begin
         if (ch_ff == LAST_CHAN) begin
            ch_in = '0;
         end else begin
            ch_in = ch_ff + 1'b1;
         end
      end
   end

   // Stage A: clamp to the stick range and multiply by the span
   always_comb begin
      sample = $signed({req_payload.stick_value[15], req_payload.stick_value});
      if (sample > LIMIT) begin
         clamped = LIMIT;
      end else if (sample < -LIMIT) begin
         clamped = -LIMIT;
      end else begin
         clamped = sample;
      end
      shifted = clamped + LIMIT;
      num     = unsigned'(shifted);
      a_in.prod     = {11'b0, num} * {17'b0, cfg.span};
      a_in.raw      = req_payload.stick_value[rcfe_pkg::VALUE_W-1:0];
      a_in.stick    = ch_ff < STICK_LIMIT;
      a_in.throttle = ch_ff == THROTTLE;
      a_in.first    = ch_ff == '0;
      a_in.last     = ch_ff == LAST_CHAN;
      a_in.bind_n   = !req_payload.bind_ended;
   end

   // Stage B: reciprocal multiply, estimate is exact or one low
   assign recip_prod = {{rcfe_pkg::PROD_W{1'b0}}, a_ff.prod}
                     * {{rcfe_pkg::PROD_W{1'b0}}, rcfe_pkg::RECIP};
   assign b_q0_in    = recip_prod[rcfe_pkg::RECIP_SHIFT +: rcfe_pkg::VALUE_W];

   // Stage C: correct the quotient, then offset or invert
   always_comb begin
      back_prod = {17'b0, b_q0_ff} * rcfe_pkg::PROD_W'(rcfe_pkg::DIVISOR);
      remainder = b_ff.prod - back_prod;
      bump      = remainder >= rcfe_pkg::PROD_W'(rcfe_pkg::DIVISOR);
      quotient  = b_q0_ff + {10'b0, bump};
      if (b_ff.throttle) begin
         scaled = cfg.span - quotient + cfg.offset;
      end else begin
         scaled = quotient + cfg.offset;
      end
      c_entry_in.value  = b_ff.stick ? scaled : b_ff.raw;
      c_entry_in.first  = b_ff.first;
      c_entry_in.last   = b_ff.last;
      c_entry_in.bind_n = b_ff.bind_n;
   end

   // Hold pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff      <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         ch_ff      <= ch_in;
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      a_ff       <= a_in;
      b_ff       <= a_ff;
      b_q0_ff    <= b_q0_in;
      c_entry_ff <= c_entry_in;
   end

   assign push_valid = c_valid_ff;
   assign push_entry = c_entry_ff;

endmodule

// File: rtl/rcfe_queue.sv
// Short queue of finished channel words between front and back.
// Register storage with one read pointer; depends on rcfe_pkg.
module rcfe_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  rcfe_pkg::chan_entry_type        push_entry,
   input  logic                            pop,
   output logic                            pop_valid,
   output rcfe_pkg::chan_entry_type        pop_entry,
   output logic [rcfe_pkg::QCNT_W-1:0]     count
);

   rcfe_pkg::chan_entry_type          store_ff [rcfe_pkg::QUEUE_DEPTH];
   logic [rcfe_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rcfe_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rcfe_pkg::QCNT_W-1:0]       count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_valid = count_ff != '0;
   assign pop_entry = store_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// File: rtl/rcfe_back.sv
// Back end: emits header bytes and packs 11-bit channel words LSB first into bytes.
// One byte per cycle, while rsp_ready takes it and a byte is ready, into a registered output; depends on rcfe_pkg.
module rcfe_back (
   input  logic                            clock,
   input  logic                            reset,
   input  rcfe_pkg::cfg_type               cfg,
   input  logic                            q_valid,
   input  rcfe_pkg::chan_entry_type        q_entry,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rcfe_pkg::rsp_payload_type       rsp_payload,
   output rcfe_pkg::back_status_type       status
);

   // Header bytes still to send after the sync byte
   localparam logic [1:0] HDR_NONE   = 2'd0;
   localparam logic [1:0] HDR_OPTION = 2'd1;
   localparam logic [1:0] HDR_TYPE   = 2'd2;
   localparam logic [1:0] HDR_BIND   = 2'd3;

   logic [1:0]                   hdr_left_ff, hdr_left_in;
   logic                         bind_n_ff, bind_n_in;
   logic                         last_ff, last_in;
   logic [rcfe_pkg::VALUE_W-1:0] hold_ff, hold_in;
   logic [3:0]                   cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rcfe_pkg::rsp_payload_type    rsp_payload_ff, rsp_payload_in;
   logic                         can_emit;
   logic                         emit;
   logic [17:0]                  merged;

   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign merged   = {7'b0, hold_ff} | ({7'b0, q_entry.value} << cnt_ff[2:0]);

   // Pick the next byte: header first, then held bits, then a new word
   always_comb begin
      hdr_left_in    = hdr_left_ff;
      bind_n_in      = bind_n_ff;
      last_in        = last_ff;
      hold_in        = hold_ff;
      cnt_in         = cnt_ff;
      rsp_payload_in = rsp_payload_ff;
      emit           = 1'b0;
      q_pop          = 1'b0;
      if (can_emit) begin
         if (hdr_left_ff != HDR_NONE) begin
            emit                      = 1'b1;
            hdr_left_in               = hdr_left_ff - 1'b1;
            rsp_payload_in.frame_end  = 1'b0;
            case (hdr_left_ff)
               HDR_BIND: begin
                  rsp_payload_in.frame_byte = {bind_n_ff, cfg.sub_protocol};
               end
               HDR_TYPE: begin
                  rsp_payload_in.frame_byte = {cfg.protocol_type, cfg.receiver_number};
               end
               HDR_OPTION: begin
                  rsp_payload_in.frame_byte = cfg.option_value;
               end
               default: begin
                  rsp_payload_in.frame_byte = rsp_payload_ff.frame_byte;
               end
            endcase
         end else if (cnt_ff >= 4'd8) begin
            // Drain a full byte of held bits
            emit                      = 1'b1;
            rsp_payload_in.frame_byte = hold_ff[7:0];
            hold_in                   = hold_ff >> 8;
            cnt_in                    = cnt_ff - 4'd8;
            rsp_payload_in.frame_end  = last_ff && (cnt_in < 4'd8);
         end else if (q_valid) begin
            emit    = 1'b1;
            q_pop   = 1'b1;
            last_in = q_entry.last;
            if (q_entry.first) begin
               // Frame start: drop leftover bits, send sync byte, queue the header
               rsp_payload_in.frame_byte = rcfe_pkg::HEAD_BYTE;
               rsp_payload_in.frame_end  = 1'b0;
               hdr_left_in               = HDR_BIND;
               bind_n_in                 = q_entry.bind_n;
               hold_in                   = q_entry.value;
               cnt_in                    = 4'(rcfe_pkg::VALUE_W);
            end else begin
               // Append the word to the held bits and send the lowest byte right away
               rsp_payload_in.frame_byte = merged[7:0];
               hold_in                   = rcfe_pkg::VALUE_W'(merged >> 8);
               cnt_in                    = cnt_ff + 4'd3;
               rsp_payload_in.frame_end  = q_entry.last && (cnt_in < 4'd8);
            end
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_left_ff  <= HDR_NONE;
         cnt_ff       <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdr_left_ff  <= hdr_left_in;
         cnt_ff       <= cnt_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bind_n_ff      <= bind_n_in;
      last_ff        <= last_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_payload_ff;
   assign status.held_bits   = cnt_ff;
   assign status.header_left = hdr_left_ff;

endmodule

// File: rtl/rc_channel_frame_encoder_top.sv
// Radio control frame encoder: 16 channel words in, 26-byte frame out (header + 22 payload).
// Words pass the front register stages and the queue, then leave through the packer's registered output.
// Output: one byte per cycle while rsp_ready takes it and a byte is ready to send;
// words are taken one per cycle while the 8-entry queue and scaling pipe have room.
// Reset clears the channel index, queue, packer and output; registers return to defaults.
// Depends on rcfe_pkg, rcfe_front, rcfe_queue, rcfe_back and the assertion macro header.
`include "rc_channel_frame_encoder_top_assert.svh"

module rc_channel_frame_encoder_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rcfe_pkg::req_payload_type             req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rcfe_pkg::rsp_payload_type             rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rcfe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rcfe_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   rcfe_pkg::cfg_type               cfg_ff, cfg_in;
   logic                            push_valid;
   rcfe_pkg::chan_entry_type        push_entry;
   logic                            q_pop;
   logic                            q_valid;
   rcfe_pkg::chan_entry_type        q_entry;
   logic [rcfe_pkg::QCNT_W-1:0]     q_count;
   rcfe_pkg::back_status_type       back_status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rcfe_pkg::CSR_SPAN:          cfg_in.span            = csr_wdata;
            rcfe_pkg::CSR_OFFSET:        cfg_in.offset          = csr_wdata;
            rcfe_pkg::CSR_SUB_PROTOCOL:  cfg_in.sub_protocol    = csr_wdata[6:0];
            rcfe_pkg::CSR_PROTOCOL_TYPE: cfg_in.protocol_type   = csr_wdata[3:0];
            rcfe_pkg::CSR_RECEIVER:      cfg_in.receiver_number = csr_wdata[3:0];
            rcfe_pkg::CSR_OPTION:        cfg_in.option_value    = csr_wdata[7:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.span            <= rcfe_pkg::SPAN_RESET;
         cfg_ff.offset          <= rcfe_pkg::OFFSET_RESET;
         cfg_ff.sub_protocol    <= '0;
         cfg_ff.protocol_type   <= '0;
         cfg_ff.receiver_number <= '0;
         cfg_ff.option_value    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .q_count     (q_count),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   rcfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry),
      .count      (q_count)
   );

   rcfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .status      (back_status)
   );

   // Credit check: the front never pushes into a full queue
   `RCFE_ASSERT_NOW(a_push_room, clock, reset, push_valid, q_count < rcfe_pkg::QCNT_W'(rcfe_pkg::QUEUE_DEPTH), "queue overflow")

   // The back never pops an empty queue
   `RCFE_ASSERT_NOW(a_pop_nonempty, clock, reset, q_pop, q_count != '0, "pop from empty queue")

   // A push without a pop grows the queue by one
   `RCFE_ASSERT_NEXT(a_count_grows, clock, reset, push_valid && !q_pop, q_count == $past(q_count) + 1'b1, "queue count mismatch")

   // The last frame byte leaves nothing held and no header pending
   `RCFE_ASSERT_NOW(a_end_clean, clock, reset, rsp_valid && rsp_payload.frame_end, back_status.held_bits == '0 && back_status.header_left == '0, "bits left over at frame end")

endmodule
